// ----- sv/uv_sphere_mesh_generator_assert.svh -----
// ---------------------------------------------------------------------------
// UV sphere mesh generator assertion macros
// Shared concurrent assertion forms, clocked on rising edge, reset low.
// ---------------------------------------------------------------------------
`ifndef UV_SPHERE_MESH_GENERATOR_ASSERT_SVH
`define UV_SPHERE_MESH_GENERATOR_ASSERT_SVH

// same-cycle implication
`define USMG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define USMG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/usmg_pkg.sv -----
// ---------------------------------------------------------------------------
// UV sphere mesh generator package
// Field widths, register indexes, CORDIC constants and helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package usmg_pkg;

    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int RING_W     = 8;
    localparam int SEG_W      = 9;
    localparam int POS_W      = 16;
    localparam int TEX_W      = 16;
    localparam int IDX_W      = 17;

    localparam int DIV_STEPS  = 33;
    localparam int DEN_W      = 11;
    localparam int ANG_W      = 32;
    localparam int TRIG_W     = 32;
    localparam int COR_W      = 34;
    localparam int PROD_W     = 64;
    localparam int ATAN_ENTRIES = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_COUNT    = 1'b0,
        CFG_SEGMENT_COUNT = 1'b1
    } t_cfg_index;

    typedef enum logic {
        FUNC_VERTEX = 1'b0,
        FUNC_CELL   = 1'b1
    } t_func;

    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic signed [COR_W-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [COR_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [COR_W-1:0] HALF_TURN    = 34'sd2147483648;

    localparam logic signed [PROD_W-1:0] POS_LIMIT = 64'sd16384;

    // sideband that rides alongside the arithmetic
    typedef struct packed {
        t_func            func;
        logic             err;
        logic [IDX_W-1:0] top;
        logic [IDX_W-1:0] bot;
    } t_side;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v;
        if (v > POS_LIMIT) begin
            t = POS_LIMIT;
        end else if (v < -POS_LIMIT) begin
            t = -POS_LIMIT;
        end
        return t[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/usmg_div.sv -----
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; the word shifts dividend bits out, quotient in.
// ---------------------------------------------------------------------------
`default_nettype none

module usmg_div #(
    parameter int STEPS = 33,
    parameter int DEN_W = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [DEN_W-1:0] i_rem,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [STEPS-1:0] i_word,
    output logic      [STEPS-1:0] o_quot
);

    logic [DEN_W-1:0] r_rem  [STEPS];
    logic [DEN_W-1:0] r_den  [STEPS];
    logic [STEPS-1:0] r_word [STEPS];
    logic [DEN_W-1:0] w_rem  [STEPS];
    logic [DEN_W-1:0] w_den  [STEPS];
    logic [STEPS-1:0] w_word [STEPS];
    logic [DEN_W-1:0] n_rem  [STEPS];
    logic [STEPS-1:0] n_word [STEPS];

    always_comb begin
        w_rem[0]  = i_rem;
        w_den[0]  = i_den;
        w_word[0] = i_word;
        for (int k = 1; k < STEPS; k++) begin
            w_rem[k]  = r_rem[k-1];
            w_den[k]  = r_den[k-1];
            w_word[k] = r_word[k-1];
        end
    end

    always_comb begin
        logic [DEN_W:0] v_sh;
        logic [DEN_W:0] v_diff;
        for (int k = 0; k < STEPS; k++) begin
            v_sh   = {w_rem[k], w_word[k][STEPS-1]};
            v_diff = v_sh - {1'b0, w_den[k]};
            if (v_sh >= {1'b0, w_den[k]}) begin
                n_rem[k]  = v_diff[DEN_W-1:0];
                n_word[k] = {w_word[k][STEPS-2:0], 1'b1};
            end else begin
                n_rem[k]  = v_sh[DEN_W-1:0];
                n_word[k] = {w_word[k][STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= w_den[k];
                r_word[k] <= n_word[k];
            end
        end
    end

    assign o_quot = r_word[STEPS-1];

endmodule

`default_nettype wire

// ----- sv/usmg_cordic.sv -----
// ---------------------------------------------------------------------------
// Pipelined rotation CORDIC
// Quadrant fold, one micro-rotation per stage, then sign restore.
// ---------------------------------------------------------------------------
`default_nettype none

module usmg_cordic #(
    parameter int ITER = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic        [usmg_pkg::ANG_W-1:0]   i_angle,
    output logic signed      [usmg_pkg::TRIG_W-1:0]  o_cos,
    output logic signed      [usmg_pkg::TRIG_W-1:0]  o_sin
);

    localparam int W = usmg_pkg::COR_W;

    logic signed [W-1:0] r_x [ITER+1];
    logic signed [W-1:0] r_y [ITER+1];
    logic signed [W-1:0] r_z [ITER+1];
    logic                r_flip [ITER+1];
    logic signed [W-1:0] w_z;
    logic signed [W-1:0] n_z0;
    logic                n_flip0;
    logic signed [W-1:0] n_cos;
    logic signed [W-1:0] n_sin;
    logic signed [usmg_pkg::TRIG_W-1:0] r_cos;
    logic signed [usmg_pkg::TRIG_W-1:0] r_sin;

    always_comb begin
        w_z     = signed'({{(W-usmg_pkg::ANG_W){i_angle[usmg_pkg::ANG_W-1]}}, i_angle});
        n_z0    = w_z;
        n_flip0 = 1'b0;
        if (w_z > usmg_pkg::QUARTER_TURN) begin
            n_z0    = w_z - usmg_pkg::HALF_TURN;
            n_flip0 = 1'b1;
        end else if (w_z < -usmg_pkg::QUARTER_TURN) begin
            n_z0    = w_z + usmg_pkg::HALF_TURN;
            n_flip0 = 1'b1;
        end
    end

    always_comb begin
        n_cos = r_flip[ITER] ? -r_x[ITER] : r_x[ITER];
        n_sin = r_flip[ITER] ? -r_y[ITER] : r_y[ITER];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= usmg_pkg::CORDIC_START;
            r_y[0]    <= '0;
            r_z[0]    <= n_z0;
            r_flip[0] <= n_flip0;
            for (int i = 0; i < ITER; i++) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - signed'({2'b00, usmg_pkg::ATAN_TURNS[i]});
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + signed'({2'b00, usmg_pkg::ATAN_TURNS[i]});
                end
                r_flip[i+1] <= r_flip[i];
            end
            r_cos <= n_cos[usmg_pkg::TRIG_W-1:0];
            r_sin <= n_sin[usmg_pkg::TRIG_W-1:0];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

`default_nettype wire

// ----- sv/usmg_delay.sv -----
// ---------------------------------------------------------------------------
// Enabled delay line
// Hold data for a fixed number of pipeline advances.
// ---------------------------------------------------------------------------
`default_nettype none

module usmg_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [WIDTH-1:0] i_data,
    output logic      [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

`default_nettype wire

// ----- sv/uv_sphere_mesh_generator.sv -----
// ---------------------------------------------------------------------------
// UV sphere mesh generator
// Vertex positions, texture coordinates and cell triangles of a unit sphere.
// ---------------------------------------------------------------------------
// Accepts one request per clock while the output is not stalled and returns
// one result per request, in order. The pipeline is two setup stages,
// 33-stage restoring dividers that form both angles and both texture
// coordinates, the CORDIC pipeline (one stage per iteration plus fold and sign
// restore), one multiply stage and the output register. Stalling the output
// freezes the whole pipeline; nothing is dropped. Configure ring_count and
// segment_count only while the pipeline is empty; o_cfg_ready is always high.
`default_nettype none

module uv_sphere_mesh_generator #(
    parameter int MAX_RINGS        = 256,
    parameter int MAX_SEGMENTS     = 256,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration write channel
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [usmg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [usmg_pkg::CFG_W-1:0]             i_cfg_data,
    // request channel
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic                                   i_func,
    input  wire logic [usmg_pkg::RING_W-1:0]            i_ring,
    input  wire logic [usmg_pkg::SEG_W-1:0]             i_segment,
    // result channel
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [usmg_pkg::POS_W-1:0]           o_pos_x,
    output logic signed [usmg_pkg::POS_W-1:0]           o_pos_y,
    output logic signed [usmg_pkg::POS_W-1:0]           o_pos_z,
    output logic        [usmg_pkg::TEX_W-1:0]           o_tex_u,
    output logic        [usmg_pkg::TEX_W-1:0]           o_tex_v,
    output logic        [usmg_pkg::IDX_W-1:0]           o_tri_a_first,
    output logic        [usmg_pkg::IDX_W-1:0]           o_tri_a_second,
    output logic        [usmg_pkg::IDX_W-1:0]           o_tri_a_third,
    output logic        [usmg_pkg::IDX_W-1:0]           o_tri_b_first,
    output logic        [usmg_pkg::IDX_W-1:0]           o_tri_b_second,
    output logic        [usmg_pkg::IDX_W-1:0]           o_tri_b_third,
    output logic                                        o_out_of_range
);

`include "uv_sphere_mesh_generator_assert.svh"

    localparam int CFG_W   = usmg_pkg::CFG_W;
    localparam int DEN_W   = usmg_pkg::DEN_W;
    localparam int STEPS   = usmg_pkg::DIV_STEPS;
    localparam int IDX_W   = usmg_pkg::IDX_W;
    localparam int PROD_W  = usmg_pkg::PROD_W;
    localparam int TRIG_W  = usmg_pkg::TRIG_W;
    localparam int TEX_W   = usmg_pkg::TEX_W;
    localparam int LAT_COR = ANGLE_ITERATIONS + 2;
    // setup x2, divider, CORDIC, multiply, output
    localparam int TOTAL   = 2 + STEPS + LAT_COR + 2;
    localparam int SIDE_W  = $bits(usmg_pkg::t_side);
    localparam logic signed [PROD_W-1:0] RND_XZ = 64'sh0000_2000_0000_0000;
    localparam logic signed [PROD_W-1:0] RND_Y  = 64'sh0000_0000_0000_8000;

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic [CFG_W-1:0] r_ring_count;
    logic [CFG_W-1:0] r_segment_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_count    <= 9'd16;
            r_segment_count <= 9'd16;
        end else if (i_cfg_valid) begin
            unique case (usmg_pkg::t_cfg_index'(i_cfg_index))
                usmg_pkg::CFG_RING_COUNT:    r_ring_count    <= i_cfg_data;
                usmg_pkg::CFG_SEGMENT_COUNT: r_segment_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // -----------------------------------------------------------------------
    // Global advance: the pipeline moves unless a held result is stalled
    // -----------------------------------------------------------------------
    logic             r_vld [TOTAL];
    logic             w_en;

    assign w_en    = !(r_vld[TOTAL-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[TOTAL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TOTAL; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < TOTAL; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stage 1: capture request, clamp the grid size
    // -----------------------------------------------------------------------
    logic [CFG_W-1:0]            n_rings;
    logic [CFG_W-1:0]            n_segs;
    usmg_pkg::t_func             r1_func;
    logic [usmg_pkg::RING_W-1:0] r1_ring;
    logic [usmg_pkg::SEG_W-1:0]  r1_seg;
    logic [CFG_W-1:0]            r1_rings;
    logic [CFG_W-1:0]            r1_segs;

    always_comb begin
        priority if (r_ring_count < 9'd2) begin
            n_rings = 9'd2;
        end else if (int'(r_ring_count) > MAX_RINGS) begin
            n_rings = CFG_W'(MAX_RINGS);
        end else begin
            n_rings = r_ring_count;
        end
        priority if (r_segment_count < 9'd3) begin
            n_segs = 9'd3;
        end else if (int'(r_segment_count) > MAX_SEGMENTS) begin
            n_segs = CFG_W'(MAX_SEGMENTS);
        end else begin
            n_segs = r_segment_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_func  <= usmg_pkg::t_func'(i_func);
            r1_ring  <= i_ring;
            r1_seg   <= i_segment;
            r1_rings <= n_rings;
            r1_segs  <= n_segs;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 2: grid check, cell indexes, divider operands
    // Each quotient is taken over 33 steps; angles use doubled operands and
    // texture ratios a 2^16 pre-scale so one divider shape serves all four.
    // -----------------------------------------------------------------------
    logic [CFG_W-1:0]   w_rm1;
    logic [CFG_W-1:0]   w_ring9;
    logic [CFG_W-1:0]   w_num_u;
    logic [CFG_W-1:0]   w_num_v;
    logic [IDX_W+1:0]   w_top;
    logic [IDX_W+1:0]   w_bot;
    usmg_pkg::t_side    n_side;
    usmg_pkg::t_side    r2_side;
    logic [DEN_W-1:0]   r2_a_rem, r2_a_den, r2_p_rem, r2_p_den;
    logic [DEN_W-1:0]   r2_u_rem, r2_u_den, r2_v_rem, r2_v_den;
    logic [STEPS-1:0]   r2_a_word, r2_p_word, r2_u_word, r2_v_word;

    always_comb begin
        w_rm1   = r1_rings - 9'd1;
        w_ring9 = {1'b0, r1_ring};
        w_num_u = r1_segs - r1_seg;
        w_num_v = w_rm1 - w_ring9;
        w_top   = (IDX_W+2)'(r1_ring) * (IDX_W+2)'({1'b0, r1_segs} + 10'd1)
                + (IDX_W+2)'(r1_seg);
        w_bot   = w_top + (IDX_W+2)'(r1_segs) + (IDX_W+2)'(1);
        n_side.func = r1_func;
        n_side.top  = w_top[IDX_W-1:0];
        n_side.bot  = w_bot[IDX_W-1:0];
        unique case (r1_func)
            usmg_pkg::FUNC_VERTEX: n_side.err = (w_ring9 >= r1_rings) || (r1_seg > r1_segs);
            usmg_pkg::FUNC_CELL:   n_side.err = ((w_ring9 + 9'd1) >= r1_rings)
                                             || (r1_seg >= r1_segs);
            default:               n_side.err = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_side   <= n_side;
            r2_a_rem  <= DEN_W'(r1_ring);
            r2_a_den  <= {w_rm1, 2'b00};
            r2_a_word <= STEPS'({w_rm1, 1'b0});
            r2_p_rem  <= DEN_W'(r1_seg);
            r2_p_den  <= {1'b0, r1_segs, 1'b0};
            r2_p_word <= STEPS'(r1_segs);
            r2_u_rem  <= DEN_W'(w_num_u);
            r2_u_den  <= {1'b0, r1_segs, 1'b0};
            r2_u_word <= STEPS'({r1_segs, 16'h0000});
            r2_v_rem  <= DEN_W'(w_num_v);
            r2_v_den  <= {1'b0, w_rm1, 1'b0};
            r2_v_word <= STEPS'({w_rm1, 16'h0000});
        end
    end

    // -----------------------------------------------------------------------
    // Dividers
    // -----------------------------------------------------------------------
    logic [STEPS-1:0] w_a_quot, w_p_quot, w_u_quot, w_v_quot;

    usmg_div #(.STEPS(STEPS), .DEN_W(DEN_W)) u_div_a (
        .i_clk(i_clk), .i_en(w_en), .i_rem(r2_a_rem), .i_den(r2_a_den),
        .i_word(r2_a_word), .o_quot(w_a_quot));
    usmg_div #(.STEPS(STEPS), .DEN_W(DEN_W)) u_div_p (
        .i_clk(i_clk), .i_en(w_en), .i_rem(r2_p_rem), .i_den(r2_p_den),
        .i_word(r2_p_word), .o_quot(w_p_quot));
    usmg_div #(.STEPS(STEPS), .DEN_W(DEN_W)) u_div_u (
        .i_clk(i_clk), .i_en(w_en), .i_rem(r2_u_rem), .i_den(r2_u_den),
        .i_word(r2_u_word), .o_quot(w_u_quot));
    usmg_div #(.STEPS(STEPS), .DEN_W(DEN_W)) u_div_v (
        .i_clk(i_clk), .i_en(w_en), .i_rem(r2_v_rem), .i_den(r2_v_den),
        .i_word(r2_v_word), .o_quot(w_v_quot));

    // saturate texture ratios, then hold them across the CORDIC and multiply stages
    logic [2*TEX_W-1:0] w_tex_in;
    logic [2*TEX_W-1:0] w_tex_out;

    assign w_tex_in = {w_u_quot[STEPS-1] ? {TEX_W{1'b1}} : w_u_quot[STEPS-2:TEX_W],
                       w_v_quot[STEPS-1] ? {TEX_W{1'b1}} : w_v_quot[STEPS-2:TEX_W]};

    usmg_delay #(.WIDTH(2*TEX_W), .DEPTH(LAT_COR + 1)) u_tex_dly (
        .i_clk(i_clk), .i_en(w_en), .i_data(w_tex_in), .o_data(w_tex_out));

    logic [SIDE_W-1:0] w_side_out;
    usmg_pkg::t_side   w_side;

    usmg_delay #(.WIDTH(SIDE_W), .DEPTH(TOTAL - 3)) u_side_dly (
        .i_clk(i_clk), .i_en(w_en), .i_data(r2_side), .o_data(w_side_out));

    assign w_side = usmg_pkg::t_side'(w_side_out);

    // -----------------------------------------------------------------------
    // Sine and cosine of latitude and longitude
    // -----------------------------------------------------------------------
    logic signed [TRIG_W-1:0] w_ca, w_sa, w_cp, w_sp;

    usmg_cordic #(.ITER(ANGLE_ITERATIONS)) u_cordic_a (
        .i_clk(i_clk), .i_en(w_en), .i_angle(w_a_quot[usmg_pkg::ANG_W-1:0]),
        .o_cos(w_ca), .o_sin(w_sa));
    usmg_cordic #(.ITER(ANGLE_ITERATIONS)) u_cordic_p (
        .i_clk(i_clk), .i_en(w_en), .i_angle(w_p_quot[usmg_pkg::ANG_W-1:0]),
        .o_cos(w_cp), .o_sin(w_sp));

    // -----------------------------------------------------------------------
    // Multiply stage
    // -----------------------------------------------------------------------
    logic signed [PROD_W-1:0] n_px, n_pz;
    logic signed [PROD_W-1:0] r_px, r_pz;
    logic signed [TRIG_W-1:0] r_ca;

    always_comb begin
        n_px = w_sa * w_cp;
        n_pz = w_sa * w_sp;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= n_px;
            r_pz <= n_pz;
            r_ca <= w_ca;
        end
    end

    // -----------------------------------------------------------------------
    // Output stage: round half up, saturate, zero unused fields
    // -----------------------------------------------------------------------
    logic signed [PROD_W-1:0] w_x_full, w_y_full, w_z_full;
    logic signed [usmg_pkg::POS_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [TEX_W-1:0] r_tex_u, r_tex_v;
    logic [IDX_W-1:0] r_a1, r_a2, r_a3, r_b1, r_b2, r_b3;
    logic             r_err;
    logic [IDX_W-1:0] w_top1, w_bot1;

    always_comb begin
        w_x_full = (-r_px + RND_XZ) >>> 46;
        w_z_full = (r_pz + RND_XZ) >>> 46;
        w_y_full = (-PROD_W'(r_ca) + RND_Y) >>> 16;
        w_top1   = w_side.top + IDX_W'(1);
        w_bot1   = w_side.bot + IDX_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_err   <= w_side.err;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_tex_u <= '0;
            r_tex_v <= '0;
            r_a1    <= '0;
            r_a2    <= '0;
            r_a3    <= '0;
            r_b1    <= '0;
            r_b2    <= '0;
            r_b3    <= '0;
            if (!w_side.err) begin
                unique case (w_side.func)
                    usmg_pkg::FUNC_VERTEX: begin
                        r_pos_x <= usmg_pkg::sat_pos(w_x_full);
                        r_pos_y <= usmg_pkg::sat_pos(w_y_full);
                        r_pos_z <= usmg_pkg::sat_pos(w_z_full);
                        r_tex_u <= w_tex_out[2*TEX_W-1:TEX_W];
                        r_tex_v <= w_tex_out[TEX_W-1:0];
                    end
                    usmg_pkg::FUNC_CELL: begin
                        r_a1 <= w_side.top;
                        r_a2 <= w_bot1;
                        r_a3 <= w_side.bot;
                        r_b1 <= w_side.top;
                        r_b2 <= w_top1;
                        r_b3 <= w_bot1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_pos_x        = r_pos_x;
    assign o_pos_y        = r_pos_y;
    assign o_pos_z        = r_pos_z;
    assign o_tex_u        = r_tex_u;
    assign o_tex_v        = r_tex_v;
    assign o_tri_a_first  = r_a1;
    assign o_tri_a_second = r_a2;
    assign o_tri_a_third  = r_a3;
    assign o_tri_b_first  = r_b1;
    assign o_tri_b_second = r_b2;
    assign o_tri_b_third  = r_b3;
    assign o_out_of_range = r_err;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `USMG_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_valid && o_out_of_range,
        o_pos_x == 0 && o_pos_y == 0 && o_tex_u == 0 && o_tri_a_first == 0 && o_tri_b_third == 0)
    `USMG_ASSERT_NOW(a_vertex_no_tri, i_clk, i_rst_n, o_valid && (o_tex_u != 0 || o_pos_y != 0),
        o_tri_a_second == 0 && o_tri_b_second == 0 && o_tri_b_third == 0)
    `USMG_ASSERT_NOW(a_pos_bound, i_clk, i_rst_n, o_valid,
        o_pos_y <= 16'sd16384 && o_pos_y >= -16'sd16384 && o_pos_x <= 16'sd16384)

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// UV sphere mesh generator testbench
// Drives vertex and cell requests under several ring/segment settings with
// random bursts and output stalls, predicts every result in fixed point and
// compares each returned transaction field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

    localparam int ITERS      = 16;
    localparam int LATENCY    = ITERS + 39;
    localparam int PHASE_REQS = 280;

    typedef struct {
        usmg_pkg::t_func func;
        logic [7:0]      ring;
        logic [8:0]      seg;
    } t_mesh_req;

    typedef struct {
        logic signed [15:0] px, py, pz;
        logic [15:0]        tu, tv;
        logic [16:0]        a1, a2, a3, b1, b2, b3;
        logic               oor;
    } t_mesh_res;

    logic i_clk, i_rst_n;
    logic i_cfg_valid, o_cfg_ready;
    logic [usmg_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [usmg_pkg::CFG_W-1:0] i_cfg_data;
    logic i_valid, o_stall, i_func;
    logic [usmg_pkg::RING_W-1:0] i_ring;
    logic [usmg_pkg::SEG_W-1:0] i_segment;
    logic o_valid, i_stall;
    logic signed [usmg_pkg::POS_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic [usmg_pkg::TEX_W-1:0] o_tex_u, o_tex_v;
    logic [usmg_pkg::IDX_W-1:0] o_tri_a_first, o_tri_a_second, o_tri_a_third;
    logic [usmg_pkg::IDX_W-1:0] o_tri_b_first, o_tri_b_second, o_tri_b_third;
    logic o_out_of_range;

    uv_sphere_mesh_generator dut (.*);

    // shadow copies of the two registers, raw bits
    logic [8:0] ring_reg, seg_reg;

    t_mesh_req pending_reqs[$];
    t_mesh_res expected_res[$];
    int        errors;
    bit        req_taken;
    int        burst_left, gap_left, stall_mode, stall_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---- fixed-point prediction -------------------------------------------

    function automatic void cordic(input logic [31:0] ang, output longint c,
                                   output longint s);
        longint z, x, y, dx, dy;
        bit flip;
        z = ang[31] ? longint'(ang) - 64'sd4294967296 : longint'(ang);
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            flip = 1'b1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(usmg_pkg::ATAN_TURNS[i]);
            end else begin
                x += dx; y -= dy; z += longint'(usmg_pkg::ATAN_TURNS[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic signed [15:0] clamp_pos(input longint v);
        if (v > 16384) return 16'sd16384;
        if (v < -16384) return -16'sd16384;
        return v[15:0];
    endfunction

    function automatic logic [15:0] tex_frac(input longint num, input longint den);
        longint t;
        t = (num * 131072 + den) / (2 * den);
        return (t > 65535) ? 16'hFFFF : t[15:0];
    endfunction

    function automatic t_mesh_res mesh_predict(input t_mesh_req q);
        t_mesh_res r;
        longint rn, sn, ring, seg, top, bot, ca, sa, cp, sp, aa, pa;
        r = '{default: '0};
        rn = ring_reg; sn = seg_reg;
        if (rn < 2) rn = 2;
        if (rn > 256) rn = 256;
        if (sn < 3) sn = 3;
        if (sn > 256) sn = 256;
        ring = q.ring; seg = q.seg;
        if (q.func == usmg_pkg::FUNC_VERTEX) begin
            if (ring >= rn || seg > sn) begin
                r.oor = 1'b1;
                return r;
            end
            aa = ((ring << 32) + (rn - 1)) / (2 * (rn - 1));
            pa = ((seg << 33) + sn) / (2 * sn);
            cordic(aa[31:0], ca, sa);
            cordic(pa[31:0], cp, sp);
            r.px = clamp_pos((-(sa * cp) + (64'sd1 <<< 45)) >>> 46);
            r.py = clamp_pos((-ca + 32768) >>> 16);
            r.pz = clamp_pos((sa * sp + (64'sd1 <<< 45)) >>> 46);
            r.tu = tex_frac(sn - seg, sn);
            r.tv = tex_frac(rn - 1 - ring, rn - 1);
        end else begin
            if (ring + 1 >= rn || seg >= sn) begin
                r.oor = 1'b1;
                return r;
            end
            top = ring * (sn + 1) + seg;
            bot = (ring + 1) * (sn + 1) + seg;
            r.a1 = top[16:0]; r.a2 = bot[16:0] + 17'd1; r.a3 = bot[16:0];
            r.b1 = top[16:0]; r.b2 = top[16:0] + 17'd1; r.b3 = bot[16:0] + 17'd1;
        end
        return r;
    endfunction

    // ---- driver: bursts from the pending queue, held while stalled ---------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !req_taken)) begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_valid   <= 1'b1;
                i_func    <= pending_reqs[0].func;
                i_ring    <= pending_reqs[0].ring;
                i_segment <= pending_reqs[0].seg;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(40, 1);
                    gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall: switch among no stall, light stall and heavy stall runs
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(2, 0);
            stall_left = $urandom_range(200, 20);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(3, 0) == 0);
            default: i_stall <= ($urandom_range(9, 0) < 7);
        endcase
    end

    // ---- accept requests and check results at the rising edge --------------

    always @(posedge i_clk) begin
        t_mesh_res e;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_res = {expected_res, mesh_predict(pending_reqs[0])};
            void'(pending_reqs.pop_front());
            req_taken = 1'b1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_res.size() == 0) begin
                $display("%0t: result transaction with nothing expected", $time);
                errors++;
            end else begin
                e = expected_res.pop_front();
                if ({o_pos_x, o_pos_y, o_pos_z, o_tex_u, o_tex_v, o_out_of_range} !==
                    {e.px, e.py, e.pz, e.tu, e.tv, e.oor} ||
                    {o_tri_a_first, o_tri_a_second, o_tri_a_third} !== {e.a1, e.a2, e.a3} ||
                    {o_tri_b_first, o_tri_b_second, o_tri_b_third} !== {e.b1, e.b2, e.b3}) begin
                    $display({"%0t: mismatch expected pos %0d %0d %0d tex %0d %0d ",
                              "tri %0d %0d %0d %0d %0d %0d oor %0d"},
                             $time, e.px, e.py, e.pz, e.tu, e.tv,
                             e.a1, e.a2, e.a3, e.b1, e.b2, e.b3, e.oor);
                    $display({"%0t:          actual pos %0d %0d %0d tex %0d %0d ",
                              "tri %0d %0d %0d %0d %0d %0d oor %0d"},
                             $time, o_pos_x, o_pos_y, o_pos_z, o_tex_u, o_tex_v,
                             o_tri_a_first, o_tri_a_second, o_tri_a_third,
                             o_tri_b_first, o_tri_b_second, o_tri_b_third, o_out_of_range);
                    errors++;
                end
            end
        end
    end

    // ---- stimulus -----------------------------------------------------------

    task automatic write_reg(input usmg_pkg::t_cfg_index idx, input logic [8:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == usmg_pkg::CFG_RING_COUNT) ring_reg = data;
        else seg_reg = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_req(input usmg_pkg::t_func f, input int ring, input int seg);
        t_mesh_req q;
        q.func = f;
        q.ring = ring[7:0];
        q.seg  = seg[8:0];
        pending_reqs = {pending_reqs, q};
    endtask

    // hold until every request is taken and every result has come back
    task automatic drain();
        while (pending_reqs.size() > 0 || expected_res.size() > 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [8:0] rc, input logic [8:0] sc, input bit directed);
        int rn, sn, r, s;
        write_reg(usmg_pkg::CFG_RING_COUNT, rc);
        write_reg(usmg_pkg::CFG_SEGMENT_COUNT, sc);
        rn = (rc < 2) ? 2 : (rc > 256) ? 256 : rc;
        sn = (sc < 3) ? 3 : (sc > 256) ? 256 : sc;
        if (directed) begin
            // grid corners, poles, seam column, just-outside and field maxima
            add_req(usmg_pkg::FUNC_VERTEX, 0, 0);
            add_req(usmg_pkg::FUNC_VERTEX, rn - 1, sn);
            add_req(usmg_pkg::FUNC_VERTEX, (rn - 1) / 2, sn / 2);
            add_req(usmg_pkg::FUNC_VERTEX, 0, sn / 4);
            add_req(usmg_pkg::FUNC_VERTEX, rn - 1, sn / 3);
            add_req(usmg_pkg::FUNC_VERTEX, rn, 0);
            add_req(usmg_pkg::FUNC_VERTEX, 0, sn + 1);
            add_req(usmg_pkg::FUNC_VERTEX, 255, 511);
            add_req(usmg_pkg::FUNC_CELL, 0, 0);
            add_req(usmg_pkg::FUNC_CELL, rn - 2, sn - 1);
            add_req(usmg_pkg::FUNC_CELL, rn - 1, 0);
            add_req(usmg_pkg::FUNC_CELL, 0, sn);
            add_req(usmg_pkg::FUNC_CELL, 255, 511);
        end
        for (int i = 0; i < PHASE_REQS; i++) begin
            if ($urandom_range(9, 0) == 0) begin
                r = $urandom_range(255, 0);
                s = $urandom_range(511, 0);
            end else begin
                r = $urandom_range(rn, 0);
                s = $urandom_range(sn + 1, 0);
            end
            add_req($urandom_range(1, 0) ? usmg_pkg::FUNC_CELL : usmg_pkg::FUNC_VERTEX, r, s);
        end
        drain();
    endtask

    initial begin
        errors = 0;
        req_taken = 1'b0;
        burst_left = 0; gap_left = 0; stall_mode = 0; stall_left = 0;
        ring_reg = 9'd16; seg_reg = 9'd16;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = usmg_pkg::CFG_RING_COUNT; i_cfg_data = '0;
        i_valid = 1'b0; i_func = usmg_pkg::FUNC_VERTEX; i_ring = '0; i_segment = '0;
        i_stall = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(9'd16, 9'd16, 1'b1);
        run_phase(9'd2, 9'd3, 1'b1);
        run_phase(9'd256, 9'd256, 1'b1);
        run_phase(9'd0, 9'd0, 1'b1);
        run_phase(9'd511, 9'd511, 1'b1);
        run_phase(9'd7, 9'd5, 1'b0);
        run_phase(9'($urandom_range(256, 2)), 9'($urandom_range(256, 3)), 1'b0);

        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && expected_res.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
